[sv/dhe_pkg.sv]
package dhe_pkg;

  localparam int COUNT_BITS = 20;
  localparam int DEPTH_BINS = 16384;
  localparam int BIN_BITS = $clog2(DEPTH_BINS);
  localparam int DEPTH_BITS = 14;
  localparam int GRAY_BITS = 8;
  localparam int DIV_STEPS = GRAY_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [BIN_BITS-1:0] addr_t;
  typedef logic [GRAY_BITS-1:0] gray_t;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam addr_t LAST_BIN = addr_t'(DEPTH_BINS - 1);
  localparam gray_t GRAY_MAX = '1;
  localparam step_t LAST_STEP = step_t'(DIV_STEPS - 1);

  localparam logic KIND_ACC = 1'b0;
  localparam logic KIND_MAP = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [DEPTH_BITS-1:0] depth;
    logic                  last;
  } pix_t;

  typedef struct packed {
    gray_t gray;
    logic  has_depth;
  } res_t;

  typedef enum logic [1:0] {
    ALU_ADD_SAT  = 2'd0,
    ALU_SUB      = 2'd1,
    ALU_DIV_STEP = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    cnt_t    a;
    cnt_t    b;
    cnt_t    lim;
  } alu_req_t;

  function automatic logic depth_ok(input logic [DEPTH_BITS-1:0] depth);
    return (depth != '0) && (32'(depth) < 32'(DEPTH_BINS));
  endfunction

endpackage

[sv/dhe_ram.sv]
module dhe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/dhe_alu.sv]
module dhe_alu (
  input  dhe_pkg::alu_req_t req,
  output dhe_pkg::cnt_t     y,
  output logic              flag
);

  logic [dhe_pkg::COUNT_BITS:0] sum;
  logic [dhe_pkg::COUNT_BITS:0] twice;
  logic [dhe_pkg::COUNT_BITS:0] diff;

  always_comb begin
    sum   = {1'b0, req.a} + {1'b0, req.b};
    twice = {req.a, 1'b0};
    diff  = twice - {1'b0, req.b};
    y     = '0;
    flag  = 1'b0;
    unique case (req.op)
      dhe_pkg::ALU_ADD_SAT: begin
        flag = sum > {1'b0, req.lim};
        y    = flag ? req.lim : sum[dhe_pkg::COUNT_BITS-1:0];
      end
      dhe_pkg::ALU_SUB: begin
        y = req.a - req.b;
      end
      dhe_pkg::ALU_DIV_STEP: begin
        flag = twice >= {1'b0, req.b};
        y    = flag ? diff[dhe_pkg::COUNT_BITS-1:0] : twice[dhe_pkg::COUNT_BITS-1:0];
      end
      default: begin
        y    = '0;
        flag = 1'b0;
      end
    endcase
  end

endmodule

[sv/depth_histogram_equalizer_top.sv]
// map word: the result is registered in ST_MAP_OUT once the output register is free, then the next word is taken
// accumulate word: bin read on accept, written in ST_ACC_WR; a clear pass and ST_ACC_RD come first when one runs
// clear pass: zeroes all DEPTH_BINS bins, on the first accumulate word after equalization
// equalization on a last accumulate word: bins 1 to DEPTH_BINS-1 one at a time, each through
// read, add, subtract, divide steps and write on the shared add/subtract/divide-step unit and the single bin ram
// reset: synchronous; a clear pass runs before the first word is taken
module depth_histogram_equalizer_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  output logic          pix_ready,
  input  dhe_pkg::pix_t pix,
  output logic          res_valid,
  input  logic          res_ready,
  output dhe_pkg::res_t res
);

  typedef enum logic [11:0] {
    ST_CLEAR   = 12'b0000_0000_0001,
    ST_IDLE    = 12'b0000_0000_0010,
    ST_MAP_OUT = 12'b0000_0000_0100,
    ST_ACC_RD  = 12'b0000_0000_1000,
    ST_ACC_WR  = 12'b0000_0001_0000,
    ST_EQ_RD0  = 12'b0000_0010_0000,
    ST_EQ_CUM0 = 12'b0000_0100_0000,
    ST_EQ_RD   = 12'b0000_1000_0000,
    ST_EQ_ADD  = 12'b0001_0000_0000,
    ST_EQ_SUB  = 12'b0010_0000_0000,
    ST_EQ_DIV  = 12'b0100_0000_0000,
    ST_EQ_WR   = 12'b1000_0000_0000
  } state_t;

  state_t state;
  dhe_pkg::addr_t idx;
  logic pend;
  logic table_is_gray;
  dhe_pkg::cnt_t point_count;
  dhe_pkg::cnt_t cum;
  dhe_pkg::cnt_t rem;
  dhe_pkg::gray_t quo;
  dhe_pkg::step_t step;
  logic full;
  logic [dhe_pkg::DEPTH_BITS-1:0] depth;
  logic last;
  logic dep_ok;

  logic ram_we;
  dhe_pkg::addr_t ram_waddr;
  dhe_pkg::cnt_t ram_wdata;
  logic ram_re;
  dhe_pkg::addr_t ram_raddr;
  dhe_pkg::cnt_t ram_rdata;

  dhe_pkg::alu_req_t alu_req;
  dhe_pkg::cnt_t alu_y;
  logic alu_flag;

  logic res_load;
  dhe_pkg::cnt_t eq_gray;

  dhe_ram #(
    .WIDTH(dhe_pkg::COUNT_BITS),
    .DEPTH(dhe_pkg::DEPTH_BINS)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  dhe_alu u_alu (
    .req (alu_req),
    .y   (alu_y),
    .flag(alu_flag)
  );

  assign pix_ready = (state == ST_IDLE);
  assign res_load = (state == ST_MAP_OUT) && (!res_valid || res_ready);

  always_comb begin
    if (point_count == '0) begin
      eq_gray = '0;
    end else if (full) begin
      eq_gray = dhe_pkg::cnt_t'(dhe_pkg::GRAY_MAX);
    end else begin
      eq_gray = dhe_pkg::cnt_t'(quo);
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    alu_req.op  = dhe_pkg::ALU_ADD_SAT;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.lim = '0;
    unique case (state)
      ST_IDLE: begin
        ram_re    = pix_valid && (pix.kind == dhe_pkg::KIND_MAP || !table_is_gray);
        ram_raddr = dhe_pkg::addr_t'(pix.depth);
      end
      ST_ACC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = dhe_pkg::addr_t'(depth);
      end
      ST_ACC_WR: begin
        alu_req.a   = ram_rdata;
        alu_req.b   = dhe_pkg::cnt_t'(1);
        alu_req.lim = '1;
        ram_we      = dep_ok;
        ram_waddr   = dhe_pkg::addr_t'(depth);
        ram_wdata   = alu_y;
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_EQ_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ST_EQ_CUM0: begin
        alu_req.a   = ram_rdata;
        alu_req.lim = point_count;
      end
      ST_EQ_RD: begin
        ram_re = 1'b1;
      end
      ST_EQ_ADD: begin
        alu_req.a   = cum;
        alu_req.b   = ram_rdata;
        alu_req.lim = point_count;
      end
      ST_EQ_SUB: begin
        alu_req.op = dhe_pkg::ALU_SUB;
        alu_req.a  = point_count;
        alu_req.b  = cum;
      end
      ST_EQ_DIV: begin
        alu_req.op = dhe_pkg::ALU_DIV_STEP;
        alu_req.a  = rem;
        alu_req.b  = point_count;
      end
      ST_EQ_WR: begin
        ram_we    = 1'b1;
        ram_wdata = eq_gray;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      idx           <= '0;
      pend          <= 1'b0;
      table_is_gray <= 1'b0;
      point_count   <= '0;
      step          <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pix_valid) begin
            depth  <= pix.depth;
            last   <= pix.last;
            dep_ok <= dhe_pkg::depth_ok(pix.depth);
            if (pix.kind == dhe_pkg::KIND_MAP) begin
              state <= ST_MAP_OUT;
            end else if (table_is_gray) begin
              table_is_gray <= 1'b0;
              point_count   <= '0;
              idx           <= '0;
              pend          <= 1'b1;
              state         <= ST_CLEAR;
            end else begin
              state <= ST_ACC_WR;
            end
          end
        end
        ST_MAP_OUT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          if (idx == dhe_pkg::LAST_BIN) begin
            pend  <= 1'b0;
            state <= pend ? ST_ACC_RD : ST_IDLE;
          end
          idx <= idx + 1'b1;
        end
        ST_ACC_RD: begin
          state <= ST_ACC_WR;
        end
        ST_ACC_WR: begin
          if (dep_ok && point_count != '1) begin
            point_count <= point_count + 1'b1;
          end
          state <= last ? ST_EQ_RD0 : ST_IDLE;
        end
        ST_EQ_RD0: begin
          idx   <= dhe_pkg::addr_t'(1);
          state <= ST_EQ_CUM0;
        end
        ST_EQ_CUM0: begin
          cum   <= alu_y;
          state <= ST_EQ_RD;
        end
        ST_EQ_RD: begin
          state <= ST_EQ_ADD;
        end
        ST_EQ_ADD: begin
          cum   <= alu_y;
          state <= ST_EQ_SUB;
        end
        ST_EQ_SUB: begin
          rem   <= alu_y;
          full  <= (cum == '0);
          quo   <= '0;
          step  <= '0;
          state <= ST_EQ_DIV;
        end
        ST_EQ_DIV: begin
          rem  <= alu_y;
          quo  <= {quo[dhe_pkg::GRAY_BITS-2:0], alu_flag};
          step <= step + 1'b1;
          if (step == dhe_pkg::LAST_STEP) begin
            state <= ST_EQ_WR;
          end
        end
        ST_EQ_WR: begin
          if (idx == dhe_pkg::LAST_BIN) begin
            table_is_gray <= 1'b1;
            state         <= ST_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_EQ_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.has_depth <= dep_ok;
      res.gray      <= (dep_ok && table_is_gray) ?
                       ram_rdata[dhe_pkg::GRAY_BITS-1:0] : '0;
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT = 1_000_000;
  localparam int CALM_WORDS = 60;

  typedef logic [dhe_pkg::DEPTH_BITS-1:0] depth_t;

  typedef struct {
    dhe_pkg::pix_t word;
    bit            drain;
  } plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_ready;
  dhe_pkg::pix_t pix = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  dhe_pkg::res_t res;

  plan_t pixel_plan[$];
  dhe_pkg::res_t gray_expect[$];

  dhe_pkg::cnt_t hist_bins[dhe_pkg::DEPTH_BINS];
  dhe_pkg::cnt_t frame_points;
  bit bins_hold_gray;

  int mismatches = 0;
  int quiet_cycles = 0;
  int words_sent = 0;
  int rx_beats = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit draining = 1'b0;
  logic calm = 1'b0;

  depth_histogram_equalizer_top uut (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix(pix),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic add_word(input logic kind, input depth_t depth,
                          input logic last, input bit drain = 1'b0);
    plan_t p;
    p.word.kind = kind;
    p.word.depth = depth;
    p.word.last = last;
    p.drain = drain;
    pixel_plan.insert(pixel_plan.size(), p);
  endtask

  task automatic account_pixel(input dhe_pkg::pix_t w);
    logic ok;
    dhe_pkg::res_t r;
    longint unsigned n, cum, g;
    int i;
    ok = (w.depth != '0) && (int'(w.depth) < dhe_pkg::DEPTH_BINS);
    if (w.kind == dhe_pkg::KIND_ACC) begin
      if (bins_hold_gray) begin
        for (i = 0; i < dhe_pkg::DEPTH_BINS; i++) hist_bins[i] = '0;
        frame_points = '0;
        bins_hold_gray = 1'b0;
      end
      if (ok) begin
        if (hist_bins[w.depth] != '1) hist_bins[w.depth] = hist_bins[w.depth] + 1'b1;
        if (frame_points != '1) frame_points = frame_points + 1'b1;
      end
      if (w.last) begin
        // running sum over bins, each bin from 1 up turns into its gray level
        n = frame_points;
        cum = hist_bins[0];
        if (cum > n) cum = n;
        for (i = 1; i < dhe_pkg::DEPTH_BINS; i++) begin
          cum += hist_bins[i];
          if (cum > n) cum = n;
          if (n != 0) begin
            g = (256 * (n - cum)) / n;
            if (g > 255) g = 255;
            hist_bins[i] = dhe_pkg::cnt_t'(g);
          end else begin
            hist_bins[i] = '0;
          end
        end
        bins_hold_gray = 1'b1;
      end
    end else begin
      r.has_depth = ok;
      r.gray = (ok && bins_hold_gray) ? dhe_pkg::gray_t'(hist_bins[w.depth]) : '0;
      gray_expect.insert(gray_expect.size(), r);
    end
  endtask

  // driver
  always @(posedge clk) begin
    plan_t nxt;
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || pix_ready) begin
      if (send_gap != 0) begin
        send_gap--;
        pix_valid <= 1'b0;
      end else if (pixel_plan.size() != 0 && pixel_plan[0].drain) begin
        pixel_plan[0].drain = 1'b0;
        draining = 1'b1;
        pix_valid <= 1'b0;
      end else if (draining && gray_expect.size() != 0) begin
        pix_valid <= 1'b0;
      end else if (pixel_plan.size() != 0) begin
        draining = 1'b0;
        if (!calm && ((words_sent / 40) % 3 != 2) && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 6) - 1;
          pix_valid <= 1'b0;
        end else begin
          nxt = pixel_plan.pop_front();
          pix <= nxt.word;
          pix_valid <= 1'b1;
          words_sent++;
        end
      end else begin
        pix_valid <= 1'b0;
      end
    end
    calm <= (pixel_plan.size() <= CALM_WORDS);
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (res_valid && res_ready) rx_beats++;
    if (rst) begin
      res_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_ready <= 1'b0;
    end else if (!calm && ((rx_beats / 30) % 3 != 1) && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    dhe_pkg::res_t want;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (gray_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected word gray=%0d has_depth=%0b",
                                    res.gray, res.has_depth));
        end else begin
          want = gray_expect.pop_front();
          if (res.gray !== want.gray) begin
            report_mismatch($sformatf("gray got %0d want %0d", res.gray, want.gray));
          end
          if (res.has_depth !== want.has_depth) begin
            report_mismatch($sformatf("has_depth got %0b want %0b",
                                      res.has_depth, want.has_depth));
          end
        end
      end
      if (pix_valid && pix_ready) account_pixel(pix);
      if ((res_valid && res_ready) || (pix_valid && pix_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int i, f, r, base, n_acc, n_map;
    depth_t d;
    depth_t seen[$];
    depth_t hot[4];

    for (i = 0; i < dhe_pkg::DEPTH_BINS; i++) hist_bins[i] = '0;
    frame_points = '0;
    bins_hold_gray = 1'b0;

    // lookups before any equalization
    add_word(dhe_pkg::KIND_MAP, 14'd0, 1'b0);
    add_word(dhe_pkg::KIND_MAP, 14'd1, 1'b0);
    add_word(dhe_pkg::KIND_MAP, 14'h3fff, 1'b1);
    add_word(dhe_pkg::KIND_MAP, 14'h2aaa, 1'b0);
    // frame with no points
    add_word(dhe_pkg::KIND_ACC, 14'd0, 1'b0);
    add_word(dhe_pkg::KIND_ACC, 14'd0, 1'b1);
    add_word(dhe_pkg::KIND_MAP, 14'd1, 1'b0);
    add_word(dhe_pkg::KIND_MAP, 14'd8191, 1'b1);
    add_word(dhe_pkg::KIND_MAP, 14'h3fff, 1'b0);
    add_word(dhe_pkg::KIND_MAP, 14'd0, 1'b0);
    // small frame, lowest counted depth is 100
    add_word(dhe_pkg::KIND_ACC, 14'd100, 1'b0);
    add_word(dhe_pkg::KIND_ACC, 14'd100, 1'b0);
    add_word(dhe_pkg::KIND_ACC, 14'd0, 1'b0);
    add_word(dhe_pkg::KIND_ACC, 14'd5000, 1'b0);
    add_word(dhe_pkg::KIND_ACC, 14'h3fff, 1'b0);
    add_word(dhe_pkg::KIND_ACC, 14'd8191, 1'b1);
    add_word(dhe_pkg::KIND_MAP, 14'd1, 1'b0);
    add_word(dhe_pkg::KIND_MAP, 14'd99, 1'b0);
    add_word(dhe_pkg::KIND_MAP, 14'd100, 1'b0);
    add_word(dhe_pkg::KIND_MAP, 14'd5000, 1'b0);
    add_word(dhe_pkg::KIND_MAP, 14'd8191, 1'b0);
    add_word(dhe_pkg::KIND_MAP, 14'h3fff, 1'b0);
    add_word(dhe_pkg::KIND_MAP, 14'd0, 1'b1);
    add_word(dhe_pkg::KIND_MAP, 14'd12000, 1'b1);

    for (f = 0; f < 2; f++) begin
      seen.delete();
      base = $urandom_range(200, 12000);
      for (i = 0; i < 4; i++) hot[i] = depth_t'($urandom_range(300, 15000));
      n_acc = $urandom_range(140, 160);
      for (i = 0; i < n_acc; i++) begin
        r = $urandom_range(0, 99);
        if (r < 10) d = '0;
        else if (r < 30) d = depth_t'($urandom_range(0, 16383));
        else if (r < 70) d = depth_t'(base + $urandom_range(0, 300));
        else d = hot[$urandom_range(0, 3)];
        if (d != '0) seen.insert(seen.size(), d);
        add_word(dhe_pkg::KIND_ACC, d, 1'b0, (f == 0 && i == 0));
        if ($urandom_range(0, 11) == 0) begin
          add_word(dhe_pkg::KIND_MAP, depth_t'($urandom_range(0, 16383)),
                   1'($urandom_range(0, 1)));
        end
      end
      d = depth_t'(base + $urandom_range(0, 300));
      seen.insert(seen.size(), d);
      add_word(dhe_pkg::KIND_ACC, d, 1'b1);
      n_map = $urandom_range(100, 120);
      for (i = 0; i < n_map; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          d = depth_t'(seen[$urandom_range(0, seen.size() - 1)] + $urandom_range(0, 2) - 1);
        end else if (r < 75) begin
          d = '0;
        end else begin
          d = depth_t'($urandom_range(0, 16383));
        end
        add_word(dhe_pkg::KIND_MAP, d, 1'($urandom_range(0, 1)));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pixel_plan.size() != 0 || pix_valid) @(posedge clk);
    while (gray_expect.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/dhe_pkg.sv
sv/dhe_ram.sv
sv/dhe_alu.sv
sv/depth_histogram_equalizer_top.sv
dv/testbench.sv
